/* hw/rtl/binary_min_heap_queue_top_assert.svh */
// assertion macros shared by the heap queue rtl
// expects clk and rst_n in the scope of each use
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH

// condition and consequence in the same cycle
`define BMHQ_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// consequence in the cycle after the condition
`define BMHQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hw/rtl/bmhq_pkg.sv */
// types, sizes and helpers for the binary min-heap queue
// no dependencies; used by controller, datapath and top level
package bmhq_pkg;

    localparam int CAPACITY      = 256;
    localparam int KEY_WIDTH     = 32;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int FIELD_W       = 32;
    localparam int OCC_W         = 9;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] payload;
    } bmhq_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] removed_payload;
        status_t            status;
        logic [OCC_W-1:0]   occupancy;
    } bmhq_result_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } heap_entry_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_TAIL,
        POS_ROOT,
        POS_PARENT,
        POS_CHILD
    } pos_op_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_PARENT,
        RD_ENDS,
        RD_CHILDREN
    } rd_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_NEW,
        WR_PARENT,
        WR_MOVER,
        WR_CHILD
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic    load_in;
        logic    load_root;
        pos_op_t pos;
        rd_op_t  rd;
        wr_op_t  wr;
        cnt_op_t cnt;
        logic    res_load;
        logic    res_got;
        status_t res_status;
    } bmhq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic parent_larger;
        logic has_child;
        logic stop_sift;
    } bmhq_stat_t;

    // heap slots count from 1, memory rows from 0
    function automatic logic [ADDR_W-1:0] slot_idx(input logic [CNT_W-1:0] slot);
        logic [CNT_W-1:0] t;
        t = slot - CNT_W'(1);
        return t[ADDR_W-1:0];
    endfunction

endpackage

/* hw/rtl/bmhq_datapath.sv */
// heap memory, entry count, position and result registers
// depends on bmhq_pkg and the assertion header
`include "binary_min_heap_queue_top_assert.svh"

module bmhq_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bmhq_pkg::bmhq_item_t   item,
    input  bmhq_pkg::bmhq_cmd_t    cmd,
    output bmhq_pkg::bmhq_stat_t   stat,
    output bmhq_pkg::bmhq_result_t result
);
    import bmhq_pkg::*;

    heap_entry_t              mem [CAPACITY];
    heap_entry_t              rd0_reg;
    heap_entry_t              rd1_reg;
    heap_entry_t              mover_reg;
    heap_entry_t              new_reg;
    logic [PAYLOAD_WIDTH-1:0] got_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         pos_next;
    bmhq_result_t             result_reg;

    logic [CNT_W-1:0]         child_slot;
    logic [CNT_W-1:0]         pick_slot;
    logic                     take_right;
    heap_entry_t              pick;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd0_addr;
    logic [ADDR_W-1:0]        rd1_addr;
    logic                     wr_en;
    heap_entry_t              wr_data;

    // left child of the current slot; right child is one above
    assign child_slot = {pos_reg[CNT_W-2:0], 1'b0};
    // right child only when it exists and is strictly smaller
    assign take_right = (child_slot < count_reg) && (rd1_reg.key < rd0_reg.key);
    assign pick       = take_right ? rd1_reg : rd0_reg;
    assign pick_slot  = take_right ? child_slot + CNT_W'(1) : child_slot;

    always_comb
    begin
        rd_en    = 1'b1;
        rd0_addr = slot_idx(child_slot);
        rd1_addr = slot_idx(child_slot + CNT_W'(1));
        unique case (cmd.rd)
            RD_NONE:
            begin
                rd_en = 1'b0;
            end
            RD_PARENT:
            begin
                rd0_addr = slot_idx(pos_reg >> 1);
                rd1_addr = slot_idx(pos_reg >> 1);
            end
            RD_ENDS:
            begin
                rd0_addr = slot_idx(CNT_W'(1));
                rd1_addr = slot_idx(count_reg);
            end
            RD_CHILDREN:
            begin
                rd0_addr = slot_idx(child_slot);
                rd1_addr = slot_idx(child_slot + CNT_W'(1));
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_data = new_reg;
        unique case (cmd.wr)
            WR_NONE:   wr_en   = 1'b0;
            WR_NEW:    wr_data = new_reg;
            WR_PARENT: wr_data = rd0_reg;
            WR_MOVER:  wr_data = mover_reg;
            WR_CHILD:  wr_data = pick;
            default:   wr_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.cnt)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = count_reg + CNT_W'(1);
            CNT_DEC:  count_next = count_reg - CNT_W'(1);
            default:  count_next = count_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.pos)
            POS_HOLD:   pos_next = pos_reg;
            POS_TAIL:   pos_next = count_reg + CNT_W'(1);
            POS_ROOT:   pos_next = CNT_W'(1);
            POS_PARENT: pos_next = pos_reg >> 1;
            POS_CHILD:  pos_next = pick_slot;
            default:    pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_idx(pos_reg)] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd0_reg <= mem[rd0_addr];
            rd1_reg <= mem[rd1_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.load_in)
        begin
            new_reg.key     <= KEY_WIDTH'(item.key);
            new_reg.payload <= PAYLOAD_WIDTH'(item.payload);
        end
        if (cmd.load_root)
        begin
            got_reg   <= rd0_reg.payload;
            mover_reg <= rd1_reg;
        end
        if (cmd.res_load)
        begin
            result_reg.removed_payload <= cmd.res_got ? FIELD_W'(got_reg) : '0;
            result_reg.status          <= cmd.res_status;
            result_reg.occupancy       <= OCC_W'(count_next);
        end
    end

    assign result = result_reg;

    assign stat.full          = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty         = (count_reg == '0);
    assign stat.at_root       = (pos_reg == CNT_W'(1));
    assign stat.parent_larger = (rd0_reg.key > new_reg.key);
    assign stat.has_child     = (pos_reg <= (count_reg >> 1));
    assign stat.stop_sift     = (mover_reg.key < pick.key);

    `BMHQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "entry count overflow")
    `BMHQ_ASSERT_NEXT(a_full_keeps_count, cmd.res_load && cmd.res_status == ST_FULL, $stable(count_reg), "rejected insert changed count")

endmodule

/* hw/rtl/bmhq_ctrl.sv */
// sequencer for insert sift-up and remove sift-down
// depends on bmhq_pkg and the assertion header
`include "binary_min_heap_queue_top_assert.svh"

module bmhq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bmhq_pkg::op_t        operation,
    input  bmhq_pkg::bmhq_stat_t stat,
    output bmhq_pkg::bmhq_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import bmhq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_RM_ROOT,
        S_RM_RD,
        S_RM_CMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        cmd        = '{load_in: 1'b0, load_root: 1'b0, pos: POS_HOLD, rd: RD_NONE,
                       wr: WR_NONE, cnt: CNT_HOLD, res_load: 1'b0, res_got: 1'b0,
                       res_status: ST_DONE};
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    if (operation == OP_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.cnt    = CNT_INC;
                            cmd.pos    = POS_TAIL;
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end
                        else
                        begin
                            // root and last entry in one go
                            cmd.rd     = RD_ENDS;
                            state_next = S_RM_ROOT;
                        end
                    end
                end
            end
            S_INS_RD:
            begin
                if (stat.at_root)
                begin
                    cmd.wr     = WR_NEW;
                    cmd.res_load = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd     = RD_PARENT;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (stat.parent_larger)
                begin
                    cmd.wr     = WR_PARENT;
                    cmd.pos    = POS_PARENT;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.wr       = WR_NEW;
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RM_ROOT:
            begin
                cmd.load_root = 1'b1;
                cmd.pos       = POS_ROOT;
                state_next    = S_RM_RD;
            end
            S_RM_RD:
            begin
                if (stat.has_child)
                begin
                    cmd.rd     = RD_CHILDREN;
                    state_next = S_RM_CMP;
                end
                else
                begin
                    cmd.wr       = WR_MOVER;
                    cmd.cnt      = CNT_DEC;
                    cmd.res_load = 1'b1;
                    cmd.res_got  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RM_CMP:
            begin
                if (stat.stop_sift)
                begin
                    cmd.wr       = WR_MOVER;
                    cmd.cnt      = CNT_DEC;
                    cmd.res_load = 1'b1;
                    cmd.res_got  = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.wr     = WR_CHILD;
                    cmd.pos    = POS_CHILD;
                    state_next = S_RM_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= cmd.res_load;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `BMHQ_ASSERT_SAME(a_done_not_busy, done_reg, !busy_reg && state_reg == S_IDLE, "result word while busy")
    `BMHQ_ASSERT_NEXT(a_child_compare, state_reg == S_RM_RD && stat.has_child, state_reg == S_RM_CMP && busy_reg, "sift-down skipped compare")
    `BMHQ_ASSERT_NEXT(a_empty_reject, state_reg == S_IDLE && start && operation == OP_REMOVE && stat.empty, done_reg && !busy_reg, "empty remove not answered at once")

endmodule

/* hw/rtl/binary_min_heap_queue_top.sv */
// Min-priority queue of key/payload pairs held as a binary heap in one on-chip memory.
// Raise start with an item word while busy is low; the item is taken at that edge.
// Exactly one result word follows, shown on result for the single cycle in which done
// is high; the receiver cannot stall it, so sample it then. A rejected insert (full)
// or a remove from an empty queue answers with done in the cycle after start. An
// insert climbs until the entry reaches the root or a parent stops it; a remove reads
// the root and last entry, then sifts the moved entry down until it ends on a leaf or
// a child compare stops it. An entry moves at most 8 levels at 256 entries. Each level
// takes a memory read state and a compare-and-write state on the single heap memory.
// No clearing pass is needed after reset. New items may start in the cycle that done
// is high.
// depends on bmhq_pkg, bmhq_ctrl and bmhq_datapath

module binary_min_heap_queue_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  bmhq_pkg::bmhq_item_t   item,
    output logic                   busy,
    output logic                   done,
    output bmhq_pkg::bmhq_result_t result
);
    import bmhq_pkg::*;

    bmhq_cmd_t  cmd;
    bmhq_stat_t stat;

    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    bmhq_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule
